/* sv/pfrp_pkg.sv */
`default_nettype none
package pfrp_pkg;

  localparam int FRAME_COUNT_DEF = 16;
  localparam int OP_W            = 2;
  localparam int FRAME_W         = 4;

  typedef enum logic [OP_W-1:0] {
    OP_TOUCH    = 2'd0,
    OP_ALLOCATE = 2'd1,
    OP_RELEASE  = 2'd2,
    OP_VICTIM   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC,
    ST_SWEEP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic look;
    logic touch;
    logic release_frame;
    logic pick_free;
    logic pick_lru;
    logic sweep;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic any_free;
    logic policy_clock;
    logic use_at_hand;
  } status_t;

endpackage
`default_nettype wire

/* sv/pfrp_if.sv */
`default_nettype none
interface pfrp_in_if;
  logic                         valid;
  logic                         ready;
  logic [pfrp_pkg::OP_W-1:0]    operation;
  logic [pfrp_pkg::FRAME_W-1:0] frame_index;

  modport source (output valid, output operation, output frame_index, input ready);
  modport sink   (input valid, input operation, input frame_index, output ready);
endinterface

interface pfrp_out_if;
  logic                         valid;
  logic                         ready;
  logic [pfrp_pkg::FRAME_W-1:0] victim_frame;
  logic                         victim_was_free;
  logic                         victim_valid;

  modport source (output valid, output victim_frame, output victim_was_free,
                  output victim_valid, input ready);
  modport sink   (input valid, input victim_frame, input victim_was_free,
                  input victim_valid, output ready);
endinterface

interface pfrp_cfg_if;
  logic valid;
  logic ready;
  logic policy_mode;

  modport source (output valid, output policy_mode, input ready);
  modport sink   (input valid, input policy_mode, output ready);
endinterface
`default_nettype wire

/* sv/pfrp_ctrl.sv */
`default_nettype none
module pfrp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              out_ready,
  output logic                   out_valid,
  input  wire pfrp_pkg::status_t status,
  output pfrp_pkg::cmd_t         cmd
);

  pfrp_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfrp_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = pfrp_pkg::ST_LOOK;
      end
      pfrp_pkg::ST_LOOK: state_nxt = pfrp_pkg::ST_EXEC;
      pfrp_pkg::ST_EXEC: begin
        if (status.op == pfrp_pkg::OP_VICTIM && !status.any_free && status.policy_clock) begin
          state_nxt = pfrp_pkg::ST_SWEEP;
        end else begin
          state_nxt = pfrp_pkg::ST_FIN;
        end
      end
      pfrp_pkg::ST_SWEEP: begin
        if (!status.use_at_hand) state_nxt = pfrp_pkg::ST_FIN;
      end
      pfrp_pkg::ST_FIN: begin
        if (slot_free) state_nxt = pfrp_pkg::ST_IDLE;
      end
      default: state_nxt = pfrp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      pfrp_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      pfrp_pkg::ST_LOOK: cmd.look = 1'b1;
      pfrp_pkg::ST_EXEC: begin
        case (status.op) inside
          pfrp_pkg::OP_TOUCH, pfrp_pkg::OP_ALLOCATE: cmd.touch = 1'b1;
          pfrp_pkg::OP_RELEASE: cmd.release_frame = 1'b1;
          default: begin
            if (status.any_free) begin
              cmd.pick_free = 1'b1;
            end else if (!status.policy_clock) begin
              cmd.pick_lru = 1'b1;
            end
          end
        endcase
      end
      pfrp_pkg::ST_SWEEP: cmd.sweep = 1'b1;
      pfrp_pkg::ST_FIN: cmd.load_out = slot_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfrp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/pfrp_dp.sv */
`default_nettype none
module pfrp_dp #(
  parameter int FRAME_COUNT = pfrp_pkg::FRAME_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [pfrp_pkg::OP_W-1:0]    in_operation,
  input  wire logic [pfrp_pkg::FRAME_W-1:0] in_frame_index,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_policy_mode,
  input  wire pfrp_pkg::cmd_t               cmd,
  output pfrp_pkg::status_t                 status,
  output logic [pfrp_pkg::FRAME_W-1:0]      out_victim_frame,
  output logic                              out_victim_was_free,
  output logic                              out_victim_valid
);

  localparam int IDX_W = $clog2(FRAME_COUNT);
  localparam int EXT_W = ((IDX_W > pfrp_pkg::FRAME_W) ? IDX_W : pfrp_pkg::FRAME_W) + 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(FRAME_COUNT - 1);

  pfrp_pkg::op_t    op_r;
  logic [IDX_W-1:0] frame_r;
  logic             in_range_r;
  logic             policy_r;

  logic [FRAME_COUNT-1:0] use_r;
  logic [FRAME_COUNT-1:0] occ_r;
  logic [IDX_W-1:0]       rank_r [FRAME_COUNT];
  logic [IDX_W-1:0]       hand_r;

  logic [IDX_W-1:0] old_rank_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             any_free_r;
  logic [IDX_W-1:0] lru_idx_r;
  logic [IDX_W-1:0] pick_r;
  logic             was_free_r;

  logic [EXT_W-1:0] f_ext;
  logic             f_in_range;
  logic [IDX_W-1:0] free_idx;
  logic             any_free;
  logic [IDX_W-1:0] lru_idx;
  logic [IDX_W-1:0] hand_next;
  logic [IDX_W-1:0] frame_next;
  logic [EXT_W-1:0] pick_ext;

  function automatic logic [IDX_W-1:0] next_frame(input logic [IDX_W-1:0] f);
    return (f == LAST) ? '0 : f + 1'b1;
  endfunction

  assign f_ext      = EXT_W'(in_frame_index);
  assign f_in_range = f_ext < EXT_W'(FRAME_COUNT);
  assign hand_next  = next_frame(hand_r);
  assign frame_next = next_frame(frame_r);
  assign pick_ext   = EXT_W'(pick_r);

  // lowest free frame
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (!occ_r[i]) begin
        free_idx = IDX_W'(i);
        any_free = 1'b1;
      end
    end
  end

  // ranks are a permutation, so exactly one entry holds rank zero
  always_comb begin
    lru_idx = '0;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      if (rank_r[i] == '0) lru_idx = lru_idx | IDX_W'(i);
    end
  end

  assign status.op           = op_r;
  assign status.any_free     = any_free_r;
  assign status.policy_clock = policy_r;
  assign status.use_at_hand  = use_r[hand_r];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= pfrp_pkg::op_t'(in_operation);
      frame_r    <= f_ext[IDX_W-1:0];
      in_range_r <= f_in_range;
    end
    if (cmd.look) begin
      old_rank_r <= in_range_r ? rank_r[frame_r] : '0;
      free_idx_r <= free_idx;
      any_free_r <= any_free;
      lru_idx_r  <= lru_idx;
    end
    if (cmd.pick_free) begin
      pick_r     <= free_idx_r;
      was_free_r <= 1'b1;
    end
    if (cmd.pick_lru) begin
      pick_r     <= lru_idx_r;
      was_free_r <= 1'b0;
    end
    if (cmd.sweep && !use_r[hand_r]) begin
      pick_r     <= hand_r;
      was_free_r <= 1'b0;
    end
    if (cmd.load_out) begin
      if (op_r == pfrp_pkg::OP_VICTIM) begin
        out_victim_frame    <= pick_ext[pfrp_pkg::FRAME_W-1:0];
        out_victim_was_free <= was_free_r;
        out_victim_valid    <= 1'b1;
      end else begin
        out_victim_frame    <= '0;
        out_victim_was_free <= 1'b0;
        out_victim_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 1'b0;
      use_r    <= '0;
      occ_r    <= '0;
      hand_r   <= '0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
        rank_r[i] <= IDX_W'(i);
      end
    end else begin
      if (cfg_we) policy_r <= cfg_policy_mode;
      if (cmd.touch && in_range_r) begin
        for (int i = 0; i < FRAME_COUNT; i++) begin
          if (IDX_W'(i) == frame_r) begin
            rank_r[i] <= LAST;
          end else if (rank_r[i] > old_rank_r) begin
            rank_r[i] <= rank_r[i] - 1'b1;
          end
        end
        use_r[frame_r] <= 1'b1;
        if (op_r == pfrp_pkg::OP_ALLOCATE) begin
          occ_r[frame_r] <= 1'b1;
          hand_r         <= frame_next;
        end
      end
      if (cmd.release_frame && in_range_r) occ_r[frame_r] <= 1'b0;
      if (cmd.pick_free || cmd.pick_lru) hand_r <= hand_next;
      if (cmd.sweep) begin
        if (use_r[hand_r]) use_r[hand_r] <= 1'b0;
        hand_r <= hand_next;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/page_frame_replacement_policy_core.sv */
// Page frame replacement policy core. Items on in_chan carry an operation
// (touch, allocate, release, choose victim) and a frame index; every item
// yields exactly one item on out_chan, in order. Frames beyond FRAME_COUNT
// are ignored by touch, allocate and release. An item is handled one at a
// time by an accept, lookup, execute, finish sequence; a victim in clock
// mode with no free frame adds a sweep between execute and finish, and
// finish waits until out_chan can take the result. The result is
// registered as finish ends, and a new item can be accepted in the cycle
// the result first shows. The sweep visits one frame per cycle, clearing
// each set use bit it meets, and picks the first frame whose use bit is
// clear; it clears at most FRAME_COUNT use bits. The output register lets
// the next item be accepted while a result waits. cfg_chan sets policy_mode
// (0 LRU, 1 clock) and is always ready; write it only while the core is idle.
// All state is in flip-flops and is ready right after reset.
`default_nettype none
module page_frame_replacement_policy_core #(
  parameter int FRAME_COUNT = pfrp_pkg::FRAME_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pfrp_in_if.sink   in_chan,
  pfrp_out_if.source out_chan,
  pfrp_cfg_if.sink  cfg_chan
);

  pfrp_pkg::cmd_t    cmd;
  pfrp_pkg::status_t status;

  assign cfg_chan.ready = 1'b1;

  pfrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .status    (status),
    .cmd       (cmd)
  );

  pfrp_dp #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_operation        (in_chan.operation),
    .in_frame_index      (in_chan.frame_index),
    .cfg_we              (cfg_chan.valid),
    .cfg_policy_mode     (cfg_chan.policy_mode),
    .cmd                 (cmd),
    .status              (status),
    .out_victim_frame    (out_chan.victim_frame),
    .out_victim_was_free (out_chan.victim_was_free),
    .out_victim_valid    (out_chan.victim_valid)
  );

endmodule
`default_nettype wire
